// ===== src/gufcc_pkg.sv =====
// ----------------------------------------------------------------------------
// gufcc_pkg: shared types and constants of the grid component counter
// Direction codes, field widths, register map and the configuration bundle
// that the register block hands to the sequencer.
// ----------------------------------------------------------------------------
package gufcc_pkg;

   // Input and result field widths.
   localparam int DIR_W  = 3;
   localparam int SET_W  = 13;

   // Direction codes carried by a request transaction.
   localparam logic [DIR_W-1:0] DIR_UP    = 3'd0;
   localparam logic [DIR_W-1:0] DIR_DOWN  = 3'd1;
   localparam logic [DIR_W-1:0] DIR_LEFT  = 3'd2;
   localparam logic [DIR_W-1:0] DIR_RIGHT = 3'd3;
   localparam logic [DIR_W-1:0] DIR_NONE  = 3'd4;

   // Grid size registers and derived counts.
   localparam int CFG_W  = 7;
   localparam int CNT_W  = 2 * CFG_W;
   localparam int RANK_W = 4;
   localparam logic [RANK_W-1:0] RANK_MAX = '1;

   // Register port.
   localparam int ADDR_W = 3;
   localparam int DATA_W = 32;
   localparam logic REG_ROWS = 1'b0;
   localparam logic REG_COLS = 1'b1;

   typedef struct packed {
      logic [CFG_W-1:0] rows;
      logic [CFG_W-1:0] cols;
      logic [CNT_W-1:0] cells;
      logic             wr;
   } cfg_type;

endpackage

// ===== src/gufcc_req_if.sv =====
// ----------------------------------------------------------------------------
// gufcc_req_if: request channel
// One transaction carries the arrow of one grid cell and the last-cell mark.
// ----------------------------------------------------------------------------
interface gufcc_req_if import gufcc_pkg::*; ();
   logic             valid;
   logic             ready;
   logic [DIR_W-1:0] direction;
   logic             last_cell;

   modport source (output valid, output direction, output last_cell, input ready);
   modport sink   (input valid, input direction, input last_cell, output ready);
endinterface

// ===== src/gufcc_rsp_if.sv =====
// ----------------------------------------------------------------------------
// gufcc_rsp_if: response channel
// One transaction carries the component count of a grid and the error flag.
// ----------------------------------------------------------------------------
interface gufcc_rsp_if import gufcc_pkg::*; ();
   logic             valid;
   logic             ready;
   logic [SET_W-1:0] set_count;
   logic             off_grid_seen;

   modport source (output valid, output set_count, output off_grid_seen, input ready);
   modport sink   (input valid, input set_count, input off_grid_seen, output ready);
endinterface

// ===== src/gufcc_ram.sv =====
// ----------------------------------------------------------------------------
// gufcc_ram: generic simple dual-port RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module gufcc_ram #(
   parameter  int WIDTH = 16,
   parameter  int DEPTH = 4096,
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== src/gufcc_csr.sv =====
// ----------------------------------------------------------------------------
// gufcc_csr: grid size registers
// APB-style register port for the row and column counts. Out-of-range
// values are clamped here, and the cell count of the grid is derived.
// ----------------------------------------------------------------------------
module gufcc_csr import gufcc_pkg::*; #(
   parameter int MAX_ROWS = 64,
   parameter int MAX_COLS = 64
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [ADDR_W-1:0] paddr,
   input  logic [DATA_W-1:0] pwdata,
   output logic [DATA_W-1:0] prdata,
   output logic              pready,
   output cfg_type           cfg
);

   localparam int FIELD_MAX = (1 << CFG_W) - 1;
   localparam int ROW_CAP   = (MAX_ROWS < FIELD_MAX) ? MAX_ROWS : FIELD_MAX;
   localparam int COL_CAP   = (MAX_COLS < FIELD_MAX) ? MAX_COLS : FIELD_MAX;
   localparam logic [CFG_W-1:0] SIZE_RESET = 7'd64;

   logic [CFG_W-1:0] rows_ff, rows_in;
   logic [CFG_W-1:0] cols_ff, cols_in;
   logic             wr_strobe;
   logic             reg_sel;
   logic [CFG_W-1:0] rows_eff;
   logic [CFG_W-1:0] cols_eff;

   assign wr_strobe = psel && penable && pwrite;
   assign reg_sel   = paddr[ADDR_W-1];
   assign pready    = 1'b1;

   always_comb begin
      rows_in = rows_ff;
      cols_in = cols_ff;
      if (wr_strobe) begin
         if (reg_sel == REG_ROWS) begin
            rows_in = pwdata[CFG_W-1:0];
         end else begin
            cols_in = pwdata[CFG_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rows_ff <= SIZE_RESET;
         cols_ff <= SIZE_RESET;
      end else begin
         rows_ff <= rows_in;
         cols_ff <= cols_in;
      end
   end

   assign prdata = (reg_sel == REG_COLS) ? DATA_W'(cols_ff) : DATA_W'(rows_ff);

   // A zero size behaves as one; a size above the maximum behaves as the maximum.
   always_comb begin
      if (rows_ff == '0) begin
         rows_eff = CFG_W'(1);
      end else if (rows_ff > CFG_W'(ROW_CAP)) begin
         rows_eff = CFG_W'(ROW_CAP);
      end else begin
         rows_eff = rows_ff;
      end
      if (cols_ff == '0) begin
         cols_eff = CFG_W'(1);
      end else if (cols_ff > CFG_W'(COL_CAP)) begin
         cols_eff = CFG_W'(COL_CAP);
      end else begin
         cols_eff = cols_ff;
      end
   end

   assign cfg.rows  = rows_eff;
   assign cfg.cols  = cols_eff;
   assign cfg.cells = CNT_W'(rows_eff) * CNT_W'(cols_eff);
   assign cfg.wr    = wr_strobe;

endmodule

// ===== src/grid_union_find_component_count.sv =====
// ----------------------------------------------------------------------------
// grid_union_find_component_count: connected components of an arrow grid
// Joins each cell to the in-grid neighbor its arrow points at in a union-find table
// (union by rank, path compression) and reports the number of sets.
// ----------------------------------------------------------------------------
//
//   channel  dir  handshake          payload
//   req      in   valid/ready        direction[2:0], last_cell
//   rsp      out  valid/ready        set_count[12:0], off_grid_seen
//   csr      in   psel/penable       paddr[2:0], pwdata[31:0], prdata[31:0]
//
// A cell without a join needs no table access. A join takes two finds, each
// walking the parent chain once to the root and once more to compress it, one
// table read per cycle, plus a link step and, on a rank tie, a rank bump; the
// single parent/rank RAM port pair sets this pace. After reset or a register
// write all MAX_ROWS*MAX_COLS table entries are cleared; after each grid the
// used rows*cols entries are cleared. req is held off during clearing, in the
// emit step and while a join is in progress. A finished count waits in an
// output register; the next grid's cells are taken while it waits.
module grid_union_find_component_count import gufcc_pkg::*; #(
   parameter int MAX_ROWS = 64,
   parameter int MAX_COLS = 64
) (
   input  logic              clock,
   input  logic              reset,
   gufcc_req_if.sink         req,
   gufcc_rsp_if.source       rsp,
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [ADDR_W-1:0] paddr,
   input  logic [DATA_W-1:0] pwdata,
   output logic [DATA_W-1:0] prdata,
   output logic              pready
);

   localparam int TABLE = MAX_ROWS * MAX_COLS;
   localparam int AW    = (TABLE > 1) ? $clog2(TABLE) : 1;
   localparam int EW    = AW + RANK_W;
   localparam logic [AW-1:0] TABLE_LAST = AW'(TABLE - 1);

   localparam logic [2:0] ST_INIT  = 3'd0;
   localparam logic [2:0] ST_CLEAR = 3'd1;
   localparam logic [2:0] ST_IDLE  = 3'd2;
   localparam logic [2:0] ST_WALK  = 3'd3;
   localparam logic [2:0] ST_COMP  = 3'd4;
   localparam logic [2:0] ST_LINK  = 3'd5;
   localparam logic [2:0] ST_BUMP  = 3'd6;
   localparam logic [2:0] ST_EMIT  = 3'd7;

   cfg_type cfg;

   logic [2:0]        state_ff, state_in;
   logic [CNT_W-1:0]  cell_ff, cell_in;
   logic [CFG_W-1:0]  row_ff, row_in;
   logic [CFG_W-1:0]  col_ff, col_in;
   logic [CNT_W-1:0]  total_ff, total_in;
   logic              err_ff, err_in;
   logic [AW-1:0]     ptr_ff, ptr_in;
   logic [AW-1:0]     clear_last_ff, clear_last_in;
   logic [AW-1:0]     cur_ff, cur_in;
   logic [AW-1:0]     start_ff, start_in;
   logic [AW-1:0]     other_ff, other_in;
   logic [AW-1:0]     root_ff, root_in;
   logic [RANK_W-1:0] rank_ff, rank_in;
   logic [AW-1:0]     a_root_ff, a_root_in;
   logic [RANK_W-1:0] a_rank_ff, a_rank_in;
   logic [AW-1:0]     hi_ff, hi_in;
   logic [RANK_W-1:0] hi_rank_ff, hi_rank_in;
   logic              phase_ff, phase_in;
   logic              pend_last_ff, pend_last_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [SET_W-1:0]  rsp_count_ff, rsp_count_in;
   logic              rsp_off_ff, rsp_off_in;

   logic              wr_en;
   logic [AW-1:0]     wr_addr;
   logic [EW-1:0]     wr_data;
   logic              rd_en;
   logic [AW-1:0]     rd_addr;
   logic [EW-1:0]     rd_data;
   logic [AW-1:0]     q_parent;
   logic [RANK_W-1:0] q_rank;

   logic              in_grid;
   logic              join_go;
   logic [CNT_W-1:0]  target;
   logic [AW-1:0]     lo;
   logic [AW-1:0]     hi;
   logic [RANK_W-1:0] lo_rank;
   logic [RANK_W-1:0] hi_rank;
   logic [2:0]        after_join;
   logic              slot_free;

   gufcc_csr #(
      .MAX_ROWS (MAX_ROWS),
      .MAX_COLS (MAX_COLS)
   ) u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   // Each entry holds the parent index above the rank.
   gufcc_ram #(
      .WIDTH (EW),
      .DEPTH (TABLE)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign q_parent = rd_data[EW-1:RANK_W];
   assign q_rank   = rd_data[RANK_W-1:0];

   assign in_grid    = cell_ff < cfg.cells;
   assign after_join = pend_last_ff ? ST_EMIT : ST_IDLE;
   assign slot_free  = !rsp_valid_ff || rsp.ready;

   // The lower-ranked root goes under the other; on a tie the first cell's root does.
   always_comb begin
      if (a_rank_ff > rank_ff) begin
         lo      = root_ff;
         lo_rank = rank_ff;
         hi      = a_root_ff;
         hi_rank = a_rank_ff;
      end else begin
         lo      = a_root_ff;
         lo_rank = a_rank_ff;
         hi      = root_ff;
         hi_rank = rank_ff;
      end
   end

   // Neighbor of the current cell and whether the arrow leaves the grid.
   always_comb begin
      join_go = 1'b0;
      target  = cell_ff;
      case (req.direction)
         DIR_UP: begin
            join_go = (row_ff != '0);
            target  = cell_ff - CNT_W'(cfg.cols);
         end
         DIR_DOWN: begin
            join_go = (row_ff != cfg.rows - CFG_W'(1));
            target  = cell_ff + CNT_W'(cfg.cols);
         end
         DIR_LEFT: begin
            join_go = (col_ff != '0);
            target  = cell_ff - CNT_W'(1);
         end
         DIR_RIGHT: begin
            join_go = (col_ff != cfg.cols - CFG_W'(1));
            target  = cell_ff + CNT_W'(1);
         end
         default: begin
            join_go = 1'b0;
            target  = cell_ff;
         end
      endcase
   end

   always_comb begin
      state_in      = state_ff;
      cell_in       = cell_ff;
      row_in        = row_ff;
      col_in        = col_ff;
      total_in      = total_ff;
      err_in        = err_ff;
      ptr_in        = ptr_ff;
      clear_last_in = clear_last_ff;
      cur_in        = cur_ff;
      start_in      = start_ff;
      other_in      = other_ff;
      root_in       = root_ff;
      rank_in       = rank_ff;
      a_root_in     = a_root_ff;
      a_rank_in     = a_rank_ff;
      hi_in         = hi_ff;
      hi_rank_in    = hi_rank_ff;
      phase_in      = phase_ff;
      pend_last_in  = pend_last_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp.ready;
      rsp_count_in  = rsp_count_ff;
      rsp_off_in    = rsp_off_ff;
      wr_en         = 1'b0;
      wr_addr       = cur_ff;
      wr_data       = '0;
      rd_en         = 1'b0;
      rd_addr       = cur_ff;

      case (state_ff)
         ST_INIT: begin
            cell_in  = '0;
            row_in   = '0;
            col_in   = '0;
            total_in = cfg.cells;
            err_in   = 1'b0;
            ptr_in   = '0;
            state_in = ST_CLEAR;
         end
         ST_CLEAR: begin
            wr_en   = 1'b1;
            wr_addr = ptr_ff;
            wr_data = {ptr_ff, RANK_W'(0)};
            if (ptr_ff == clear_last_ff) begin
               state_in = ST_IDLE;
            end else begin
               ptr_in = ptr_ff + AW'(1);
            end
         end
         ST_IDLE: begin
            if (req.valid) begin
               pend_last_in = req.last_cell;
               if (in_grid) begin
                  cell_in = cell_ff + CNT_W'(1);
                  if (col_ff == cfg.cols - CFG_W'(1)) begin
                     col_in = '0;
                     row_in = row_ff + CFG_W'(1);
                  end else begin
                     col_in = col_ff + CFG_W'(1);
                  end
                  if (!join_go && req.direction <= DIR_RIGHT) begin
                     err_in = 1'b1;
                  end
               end
               if (in_grid && join_go) begin
                  cur_in   = AW'(cell_ff);
                  start_in = AW'(cell_ff);
                  other_in = AW'(target);
                  phase_in = 1'b0;
                  rd_en    = 1'b1;
                  rd_addr  = AW'(cell_ff);
                  state_in = ST_WALK;
               end else if (req.last_cell) begin
                  state_in = ST_EMIT;
               end
            end
         end
         ST_WALK: begin
            rd_en = 1'b1;
            if (q_parent == cur_ff) begin
               root_in  = cur_ff;
               rank_in  = q_rank;
               cur_in   = start_ff;
               rd_addr  = start_ff;
               state_in = ST_COMP;
            end else begin
               cur_in  = q_parent;
               rd_addr = q_parent;
            end
         end
         ST_COMP: begin
            if (cur_ff == root_ff) begin
               if (!phase_ff) begin
                  a_root_in = root_ff;
                  a_rank_in = rank_ff;
                  phase_in  = 1'b1;
                  cur_in    = other_ff;
                  start_in  = other_ff;
                  rd_en     = 1'b1;
                  rd_addr   = other_ff;
                  state_in  = ST_WALK;
               end else begin
                  state_in = ST_LINK;
               end
            end else begin
               // Point this node straight at the root and follow its old parent.
               wr_en   = 1'b1;
               wr_addr = cur_ff;
               wr_data = {root_ff, q_rank};
               rd_en   = 1'b1;
               rd_addr = q_parent;
               cur_in  = q_parent;
            end
         end
         ST_LINK: begin
            if (a_root_ff == root_ff) begin
               state_in = after_join;
            end else begin
               wr_en   = 1'b1;
               wr_addr = lo;
               wr_data = {hi, lo_rank};
               if (total_ff != '0) begin
                  total_in = total_ff - CNT_W'(1);
               end
               if (lo_rank == hi_rank && hi_rank != RANK_MAX) begin
                  hi_in      = hi;
                  hi_rank_in = hi_rank;
                  state_in   = ST_BUMP;
               end else begin
                  state_in = after_join;
               end
            end
         end
         ST_BUMP: begin
            wr_en    = 1'b1;
            wr_addr  = hi_ff;
            wr_data  = {hi_ff, hi_rank_ff + RANK_W'(1)};
            state_in = after_join;
         end
         ST_EMIT: begin
            if (slot_free) begin
               rsp_valid_in  = 1'b1;
               rsp_count_in  = total_ff[SET_W-1:0];
               rsp_off_in    = err_ff;
               clear_last_in = AW'(cfg.cells - CNT_W'(1));
               state_in      = ST_INIT;
            end
         end
         default: begin
            state_in = ST_INIT;
         end
      endcase

      // A register write abandons the grid and clears the whole table.
      if (cfg.wr) begin
         state_in      = ST_INIT;
         clear_last_in = TABLE_LAST;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_INIT;
         clear_last_ff <= TABLE_LAST;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         clear_last_ff <= clear_last_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cell_ff      <= cell_in;
      row_ff       <= row_in;
      col_ff       <= col_in;
      total_ff     <= total_in;
      err_ff       <= err_in;
      ptr_ff       <= ptr_in;
      cur_ff       <= cur_in;
      start_ff     <= start_in;
      other_ff     <= other_in;
      root_ff      <= root_in;
      rank_ff      <= rank_in;
      a_root_ff    <= a_root_in;
      a_rank_ff    <= a_rank_in;
      hi_ff        <= hi_in;
      hi_rank_ff   <= hi_rank_in;
      phase_ff     <= phase_in;
      pend_last_ff <= pend_last_in;
      rsp_count_ff <= rsp_count_in;
      rsp_off_ff   <= rsp_off_in;
   end

   assign req.ready         = (state_ff == ST_IDLE);
   assign rsp.valid         = rsp_valid_ff;
   assign rsp.set_count     = rsp_count_ff;
   assign rsp.off_grid_seen = rsp_off_ff;

   // A register write always restarts the grid.
   a_cfg_restart : assert property (@(posedge clock) disable iff (reset)
      cfg.wr |=> state_ff == ST_INIT)
      else $error("register write did not restart the grid");

   // Neither the cell counter nor the set count may pass the grid size.
   a_count_bound : assert property (@(posedge clock) disable iff (reset)
      state_ff != ST_INIT |-> (cell_ff <= cfg.cells && total_ff <= cfg.cells))
      else $error("cell or set count exceeds the grid size");

   // A response transaction is only launched from the emit step.
   a_rsp_source : assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == ST_EMIT)
      else $error("response raised outside the emit step");

endmodule
